### src/rwlt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rwlt_pkg;

  localparam int TABLE_SLOTS_DEF = 16;
  localparam int KEY_COUNT_DEF = 128;

  localparam int KEY_W = 7;
  localparam int CNT_W = 5;
  localparam int STATUS_W = 3;
  localparam int OP_W = 2;

  localparam logic [CNT_W-1:0] LIMIT_RESET = 5'd10;
  localparam logic [CNT_W-1:0] CNT_MAX = 5'd31;

  localparam logic [OP_W-1:0] OP_ACQ_READ = 2'd0;
  localparam logic [OP_W-1:0] OP_REL_READ = 2'd1;
  localparam logic [OP_W-1:0] OP_ACQ_WRITE = 2'd2;
  localparam logic [OP_W-1:0] OP_REL_WRITE = 2'd3;

  localparam logic [STATUS_W-1:0] ST_GRANTED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_WAIT_FULL = 3'd1;
  localparam logic [STATUS_W-1:0] ST_WAIT_WRITER = 3'd2;
  localparam logic [STATUS_W-1:0] ST_WAIT_READER = 3'd3;
  localparam logic [STATUS_W-1:0] ST_RELEASED = 3'd4;
  localparam logic [STATUS_W-1:0] ST_LAST_READER = 3'd5;
  localparam logic [STATUS_W-1:0] ST_ERROR = 3'd6;

  typedef struct packed {
    logic capture;
    logic execute;
  } rwlt_cmd_t;

  typedef struct packed {
    logic out_free;
  } rwlt_stat_t;

endpackage

`default_nettype wire

### src/rwlt_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module rwlt_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_tvalid,
  output logic                    s_tready,
  input  wire rwlt_pkg::rwlt_stat_t stat,
  output rwlt_pkg::rwlt_cmd_t     cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state;
  logic state_next;

  always_comb begin
    state_next = state;
    cmd = '0;
    s_tready = (state == ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (stat.out_free) begin
          cmd.execute = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_capture_enters_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> (state == ST_EXEC))
    else $error("captured request did not enter execution");

  a_execute_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd.execute |-> stat.out_free)
    else $error("request executed while the output register was occupied");

endmodule

`default_nettype wire

### src/rwlt_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module rwlt_datapath #(
  parameter int TABLE_SLOTS = rwlt_pkg::TABLE_SLOTS_DEF,
  parameter int KEY_COUNT = rwlt_pkg::KEY_COUNT_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire rwlt_pkg::rwlt_cmd_t             cmd,
  output rwlt_pkg::rwlt_stat_t                 stat,
  input  wire logic [rwlt_pkg::KEY_W-1:0]      req_key,
  input  wire logic [rwlt_pkg::OP_W-1:0]       req_op,
  input  wire logic                            holder_limit_we,
  input  wire logic [rwlt_pkg::CNT_W-1:0]      holder_limit_wdata,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic [rwlt_pkg::STATUS_W-1:0]        res_status,
  output logic                                 res_wake_readers,
  output logic                                 res_wake_writers,
  output logic [rwlt_pkg::CNT_W-1:0]           res_holders_active
);

  localparam int SW = $clog2(TABLE_SLOTS);
  localparam int KW = rwlt_pkg::KEY_W;
  localparam int CW = rwlt_pkg::CNT_W;

  logic [rwlt_pkg::OP_W-1:0] op_q;
  logic [KW-1:0]             key_q;
  logic [CW-1:0]             holder_limit;
  logic [CW-1:0]             active_holders;
  logic [CW-1:0]             active_holders_next;

  logic [TABLE_SLOTS-1:0] slot_valid;
  logic [KW-1:0]          slot_key [TABLE_SLOTS];
  logic                   slot_is_write [TABLE_SLOTS];
  logic [CW-1:0]          slot_holders [TABLE_SLOTS];

  logic          rd_hit;
  logic [SW-1:0] rd_idx;
  logic          wr_hit;
  logic [SW-1:0] wr_idx;
  logic          free_hit;
  logic [SW-1:0] free_idx;

  logic          key_ok;
  logic          full;
  logic [CW-1:0] rd_holders;
  logic [CW-1:0] rd_holders_dec;

  logic          we;
  logic [SW-1:0] we_idx;
  logic          we_valid;
  logic          we_is_write;
  logic [CW-1:0] we_holders;
  logic [rwlt_pkg::STATUS_W-1:0] status_next;
  logic          wake_next;

  always_comb begin
    rd_hit = 1'b0;
    rd_idx = '0;
    wr_hit = 1'b0;
    wr_idx = '0;
    free_hit = 1'b0;
    free_idx = '0;
    for (int i = TABLE_SLOTS - 1; i >= 0; i--) begin
      if (slot_valid[i] && slot_key[i] == key_q && !slot_is_write[i]) begin
        rd_hit = 1'b1;
        rd_idx = SW'(i);
      end
      if (slot_valid[i] && slot_key[i] == key_q && slot_is_write[i]) begin
        wr_hit = 1'b1;
        wr_idx = SW'(i);
      end
      if (!slot_valid[i]) begin
        free_hit = 1'b1;
        free_idx = SW'(i);
      end
    end
  end

  assign key_ok = (32'(key_q) < KEY_COUNT);
  assign full = (active_holders >= holder_limit);
  assign rd_holders = slot_holders[rd_idx];
  assign rd_holders_dec = (rd_holders != '0) ? rd_holders - CW'(1) : '0;

  always_comb begin
    status_next = rwlt_pkg::ST_ERROR;
    wake_next = 1'b0;
    active_holders_next = active_holders;
    we = 1'b0;
    we_idx = free_idx;
    we_valid = 1'b1;
    we_is_write = 1'b0;
    we_holders = CW'(1);
    if (key_ok) begin
      unique case (op_q)
        rwlt_pkg::OP_ACQ_READ: begin
          if (full) begin
            status_next = rwlt_pkg::ST_WAIT_FULL;
          end else if (wr_hit) begin
            status_next = rwlt_pkg::ST_WAIT_WRITER;
          end else if (rd_hit) begin
            we = 1'b1;
            we_idx = rd_idx;
            we_holders = (rd_holders == rwlt_pkg::CNT_MAX) ? rd_holders
                                                           : rd_holders + CW'(1);
            status_next = rwlt_pkg::ST_GRANTED;
          end else if (!free_hit) begin
            status_next = rwlt_pkg::ST_WAIT_FULL;
          end else begin
            we = 1'b1;
            status_next = rwlt_pkg::ST_GRANTED;
          end
        end
        rwlt_pkg::OP_REL_READ: begin
          if (rd_hit) begin
            we = 1'b1;
            we_idx = rd_idx;
            we_holders = rd_holders_dec;
            we_valid = (rd_holders_dec != '0);
            status_next = (rd_holders_dec == '0) ? rwlt_pkg::ST_LAST_READER
                                                 : rwlt_pkg::ST_RELEASED;
            wake_next = 1'b1;
          end
        end
        rwlt_pkg::OP_ACQ_WRITE: begin
          we_is_write = 1'b1;
          if (full) begin
            status_next = rwlt_pkg::ST_WAIT_FULL;
          end else if (rd_hit) begin
            status_next = rwlt_pkg::ST_WAIT_READER;
          end else if (wr_hit) begin
            status_next = rwlt_pkg::ST_WAIT_WRITER;
          end else if (!free_hit) begin
            status_next = rwlt_pkg::ST_WAIT_FULL;
          end else begin
            we = 1'b1;
            status_next = rwlt_pkg::ST_GRANTED;
          end
        end
        rwlt_pkg::OP_REL_WRITE: begin
          we_is_write = 1'b1;
          if (wr_hit) begin
            we = 1'b1;
            we_idx = wr_idx;
            we_valid = 1'b0;
            status_next = rwlt_pkg::ST_RELEASED;
            wake_next = 1'b1;
          end
        end
        default: begin
          status_next = rwlt_pkg::ST_ERROR;
        end
      endcase
    end
    if (status_next == rwlt_pkg::ST_GRANTED && active_holders != rwlt_pkg::CNT_MAX) begin
      active_holders_next = active_holders + CW'(1);
    end else if (wake_next && active_holders != '0) begin
      active_holders_next = active_holders - CW'(1);
    end
  end

  assign stat.out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q <= req_op;
      key_q <= req_key;
    end
    if (cmd.execute && we) begin
      slot_key[we_idx] <= key_q;
      slot_is_write[we_idx] <= we_is_write;
      slot_holders[we_idx] <= we_holders;
    end
    if (cmd.execute) begin
      res_status <= status_next;
      res_wake_readers <= wake_next;
      res_wake_writers <= wake_next;
      res_holders_active <= active_holders_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      active_holders <= '0;
      holder_limit <= rwlt_pkg::LIMIT_RESET;
      m_tvalid <= 1'b0;
    end else begin
      if (holder_limit_we) begin
        holder_limit <= holder_limit_wdata;
      end
      if (cmd.execute) begin
        active_holders <= active_holders_next;
        if (we) begin
          slot_valid[we_idx] <= we_valid;
        end
      end
      if (cmd.execute) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  a_execute_fills_output: assert property (@(posedge clk) disable iff (rst)
    cmd.execute |=> m_tvalid)
    else $error("executed request produced no result");

  a_grant_counts_up: assert property (@(posedge clk) disable iff (rst)
    (cmd.execute && status_next == rwlt_pkg::ST_GRANTED &&
     active_holders != rwlt_pkg::CNT_MAX)
    |=> (active_holders == $past(active_holders) + CW'(1)))
    else $error("grant did not raise the holder count");

  a_result_matches_count: assert property (@(posedge clk) disable iff (rst)
    cmd.execute |=> (res_holders_active == active_holders))
    else $error("reported holder count differs from the table count");

endmodule

`default_nettype wire

### src/reader_writer_lock_table_core.sv
// Reader/writer lock table.
// Requests arrive on the s_ channel: s_tuser carries the opcode (acquire read,
// release read, acquire write, release write) and s_tdata carries the key.
// Each request produces exactly one response on the m_ channel with a status,
// the two wake flags and the active holder count after the request.
// A request is accepted while the block is idle, in the controller's capture
// step; its execute step, taken once the output register is free, registers
// the response in the output register together with the single table
// update. The next request can be accepted while a response waits in the
// output register. When the receiver stalls with a response still held, the
// block finishes capturing one more request and then holds it until the
// output register frees up. Reset clears every table entry, the holder count
// and the output register, and loads the holder limit with ten. The holder
// limit is written through holder_limit_we and holder_limit_wdata; the user
// must do so only while no request is in flight, as the block does not check.
`timescale 1ns / 1ps
`default_nettype none

module reader_writer_lock_table_core #(
  parameter int TABLE_SLOTS = rwlt_pkg::TABLE_SLOTS_DEF,
  parameter int KEY_COUNT = rwlt_pkg::KEY_COUNT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // lock_key[6:0], zero[7]
  input  wire logic [7:0]  s_tdata,
  // opcode[1:0]
  input  wire logic [1:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // status[2:0], wake_readers[3], wake_writers[4], holders_active[9:5], zero[15:10]
  output logic [15:0]      m_tdata,
  input  wire logic        holder_limit_we,
  input  wire logic [4:0]  holder_limit_wdata
);

  rwlt_pkg::rwlt_cmd_t  cmd;
  rwlt_pkg::rwlt_stat_t stat;

  logic [rwlt_pkg::STATUS_W-1:0] res_status;
  logic                          res_wake_readers;
  logic                          res_wake_writers;
  logic [rwlt_pkg::CNT_W-1:0]    res_holders_active;

  rwlt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rwlt_datapath #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .KEY_COUNT   (KEY_COUNT)
  ) u_datapath (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .stat               (stat),
    .req_key            (s_tdata[6:0]),
    .req_op             (s_tuser),
    .holder_limit_we    (holder_limit_we),
    .holder_limit_wdata (holder_limit_wdata),
    .m_tvalid           (m_tvalid),
    .m_tready           (m_tready),
    .res_status         (res_status),
    .res_wake_readers   (res_wake_readers),
    .res_wake_writers   (res_wake_writers),
    .res_holders_active (res_holders_active)
  );

  assign m_tdata = {6'b0, res_holders_active, res_wake_writers, res_wake_readers, res_status};

endmodule

`default_nettype wire
